/* hdl/hid_keyboard_report_builder_unit_macros.svh */
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_unit_macros.svh
// assertion macros used by the report builder unit
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_BUILDER_UNIT_MACROS_SVH
`define HID_KEYBOARD_REPORT_BUILDER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HKRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define HKRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/hkrb_pkg.sv */
// ----------------------------------------------------------------------------
// hkrb_pkg
// types and constants of the boot keyboard report builder
// ----------------------------------------------------------------------------
package hkrb_pkg;

	// table geometry
	localparam int MAX_SLOTS = 6;
	localparam int KEY_SLOTS = 6;

	// key code decoding
	localparam logic [7:0] MOD_MASK = 8'hF8;
	localparam logic [7:0] MOD_BASE = 8'hE0;
	localparam logic [7:0] MOD_SEL  = 8'h07;
	localparam logic [7:0] NO_KEY   = 8'h00;

	// event codes
	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_RESET   = 2'd2
	} op_t;

	typedef logic [MAX_SLOTS-1:0][7:0] slots_t;

	// outcome of one event applied to the held state
	typedef struct packed {
		logic       changed;
		logic [7:0] mods;
		slots_t     keys;
	} upd_t;

endpackage

/* hdl/hid_keyboard_report_builder_unit.sv */
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_unit
// boot keyboard report keeper: modifier byte plus six compacted key slots
//
// a key event (op, keycode) is taken at a clock edge with start high and
// busy low; busy stays low, so one event can enter every cycle
// events pass through an input register, are applied to the held state by
// one level of compare and select logic, and the held state is written back
// a report is driven from the held-state registers, valid high for exactly
// one cycle, with modifier_bits and key_slot_0..5 holding the new state;
// throughput is one event per cycle, set by the single state update path
// between the input register and the held-state registers
// an event that changes nothing gives no report; a reset event always does
// the receiver cannot stall: each report must be taken in its valid cycle
// arst_n clears the held state and drops valid; no report comes out of it
// ----------------------------------------------------------------------------
`include "hid_keyboard_report_builder_unit_macros.svh"

module hid_keyboard_report_builder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] op,
	input  logic [7:0] keycode,
	output logic       valid,
	output logic [7:0] modifier_bits,
	output logic [7:0] key_slot_0,
	output logic [7:0] key_slot_1,
	output logic [7:0] key_slot_2,
	output logic [7:0] key_slot_3,
	output logic [7:0] key_slot_4,
	output logic [7:0] key_slot_5
);

	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [7:0]       keycode_s1;
	logic [7:0]       held_mods_q;
	hkrb_pkg::slots_t held_keys_q;
	logic             valid_q;
	hkrb_pkg::upd_t   upd;

	// never stalls the sender
	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1      <= op;
			keycode_s1 <= keycode;
		end
	end

	// event applied to the held state
	hkrb_update u_update (
		.op        (op_s1),
		.keycode   (keycode_s1),
		.held_mods (held_mods_q),
		.held_keys (held_keys_q),
		.upd       (upd)
	);

	// held state doubles as the report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_mods_q <= 8'h00;
			held_keys_q <= '0;
			valid_q     <= 1'b0;
		end else begin
			valid_q <= valid_s1 & upd.changed;
			if (valid_s1 && upd.changed) begin
				held_mods_q <= upd.mods;
				held_keys_q <= upd.keys;
			end
		end
	end

	// report ports
	assign valid         = valid_q;
	assign modifier_bits = held_mods_q;
	assign key_slot_0    = held_keys_q[0];
	assign key_slot_1    = held_keys_q[1];
	assign key_slot_2    = held_keys_q[2];
	assign key_slot_3    = held_keys_q[3];
	assign key_slot_4    = held_keys_q[4];
	assign key_slot_5    = held_keys_q[5];

	// checks
	`HKRB_ASSERT_NOW(a_report_has_event, clk, arst_n, valid_q, $past(valid_s1), "report without an event")
	`HKRB_ASSERT_NOW(a_quiet_state, clk, arst_n, !valid_q, $stable(held_mods_q) && $stable(held_keys_q), "held state moved without a report")
	`HKRB_ASSERT_NOW(a_slots_compact, clk, arst_n, held_keys_q[0] == hkrb_pkg::NO_KEY, held_keys_q == '0, "key slots not compacted")
	`HKRB_ASSERT_NEXT(a_reset_event, clk, arst_n, valid_s1 && op_s1 == hkrb_pkg::OP_RESET, valid_q && held_mods_q == 8'h00 && held_keys_q == '0, "reset event did not clear and report")

endmodule

/* hdl/hkrb_update.sv */
// ----------------------------------------------------------------------------
// hkrb_update
// applies one key event to the held modifiers and key slots
// ----------------------------------------------------------------------------
module hkrb_update (
	input  logic [1:0]      op,
	input  logic [7:0]      keycode,
	input  logic [7:0]      held_mods,
	input  hkrb_pkg::slots_t held_keys,
	output hkrb_pkg::upd_t  upd
);

	always_comb begin
		logic [7:0]                     mod_bit;
		logic                           is_mod;
		logic                           hit;
		logic                           placed;
		logic                           shifting;
		logic [hkrb_pkg::MAX_SLOTS:0][7:0] ext_keys;
		hkrb_pkg::slots_t               press_keys;
		hkrb_pkg::slots_t               rel_keys;

		// modifier decode
		mod_bit = 8'h01 << keycode[2:0];
		is_mod  = ((keycode & hkrb_pkg::MOD_MASK) == hkrb_pkg::MOD_BASE);

		// slots padded with an empty entry for the shift-down
		ext_keys = {hkrb_pkg::NO_KEY, held_keys};

		// parallel compare against every slot
		hit = 1'b0;
		for (int i = 0; i < hkrb_pkg::KEY_SLOTS; i++) begin
			if (held_keys[i] == keycode) begin
				hit = 1'b1;
			end
		end

		// append into the first empty slot
		press_keys = held_keys;
		placed     = 1'b0;
		for (int i = 0; i < hkrb_pkg::KEY_SLOTS; i++) begin
			if (!placed && held_keys[i] == hkrb_pkg::NO_KEY) begin
				press_keys[i] = keycode;
				placed        = 1'b1;
			end
		end

		// remove the matching slot, later slots move down
		rel_keys = held_keys;
		shifting = 1'b0;
		for (int j = 0; j < hkrb_pkg::KEY_SLOTS; j++) begin
			if (held_keys[j] == keycode) begin
				shifting = 1'b1;
			end
			if (shifting) begin
				rel_keys[j] = (j + 1 < hkrb_pkg::KEY_SLOTS) ? ext_keys[j + 1] : hkrb_pkg::NO_KEY;
			end
		end

		// event decode
		upd.changed = 1'b0;
		upd.mods    = held_mods;
		upd.keys    = held_keys;
		unique case (hkrb_pkg::op_t'(op))
			hkrb_pkg::OP_PRESS: begin
				if (keycode != hkrb_pkg::NO_KEY) begin
					if (is_mod) begin
						upd.changed = ((held_mods & mod_bit) == 8'h00);
						upd.mods    = held_mods | mod_bit;
					end else if (!hit && placed) begin
						upd.changed = 1'b1;
						upd.keys    = press_keys;
					end
				end
			end
			hkrb_pkg::OP_RELEASE: begin
				if (keycode != hkrb_pkg::NO_KEY) begin
					if (is_mod) begin
						upd.changed = ((held_mods & mod_bit) != 8'h00);
						upd.mods    = held_mods & ~mod_bit;
					end else if (hit) begin
						upd.changed = 1'b1;
						upd.keys    = rel_keys;
					end
				end
			end
			hkrb_pkg::OP_RESET: begin
				upd.changed = 1'b1;
				upd.mods    = 8'h00;
				upd.keys    = '0;
			end
			default: begin
				upd.changed = 1'b0;
			end
		endcase
	end

endmodule
